FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with async reset gating.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/dlr_pkg.sv
// ---------------------------------------------------------------------------
// dlr_pkg
// Shared constants, types and codes of the DDA line rasterizer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlr_pkg;

	// fixed-point format
	localparam int FRAC_BITS  = 8;
	localparam int LIMIT_BITS = 10;
	localparam int POS_W      = 24;
	localparam int DIFF_W     = POS_W + 1;
	localparam int NUM_W      = DIFF_W + FRAC_BITS;
	localparam int QUO_W      = 17;
	localparam int CNT_W      = $clog2(QUO_W + 1);
	localparam int WGT_W      = 17;
	localparam int OUT_WGT_W  = 16;
	localparam int PIX_W      = 12;
	localparam int DIM_W      = 13;
	localparam int TRUNC_W    = POS_W - 1 - FRAC_BITS;

	// stream and register port widths
	localparam int IN_DATA_W  = 4 * POS_W;
	localparam int OUT_DATA_W = 2 * PIX_W + OUT_WGT_W;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;

	localparam logic [WGT_W-1:0]   WEIGHT_ONE = WGT_W'(1) << 16;
	localparam logic [NUM_W-1:0]   WEIGHT_NUM = NUM_W'(1) << (16 + FRAC_BITS);
	localparam logic [TRUNC_W-1:0] PIX_LIMIT  = TRUNC_W'(1) << PIX_W;

	// register reset values
	localparam logic [DIM_W-1:0]      WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0]      HEIGHT_RST = DIM_W'(768);
	localparam logic [LIMIT_BITS-1:0] LIMIT_RST  = LIMIT_BITS'(1000);

	// input word kinds
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_STEP_LIMIT    = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABS,
		ST_MAX,
		ST_PLAN,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DIV_W,
		ST_STEP
	} state_t;

	typedef struct packed {
		logic [DIM_W-1:0]      screen_width;
		logic [DIM_W-1:0]      screen_height;
		logic [LIMIT_BITS-1:0] step_limit;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  numer;
		logic [DIFF_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [QUO_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic                 valid;
		logic [PIX_W-1:0]     pixel_x;
		logic [PIX_W-1:0]     pixel_y;
		logic [OUT_WGT_W-1:0] blend_weight;
		logic                 visible;
		logic                 last;
	} result_t;

endpackage

FILE: rtl/dda_line_rasterizer.sv
// ---------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line walker with fixed-point endpoints and a blend weight output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// A load word (tuser 0) takes Q15.8 start and end points and sets up the
// walk; it produces no output word and occupies the block until the setup
// ends. A zero-length line needs no division; otherwise the shared
// one-bit-per-cycle divider computes the x increment, the y increment and,
// unless the longer axis spans under one pixel, the weight step in turn.
// A step word (tuser 1) produces one output word: the pixel, its visible
// flag (tuser) and the weight, or tlast=1 once the walk has ended. The
// output register lets a new word in while a result waits; a step stalls
// only while that register is still full.
module dda_line_rasterizer (
	input  logic                               clk,
	input  logic                               arst_n,
	// stream in
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [dlr_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // start_x, start_y, end_x, end_y
	input  logic [0:0]                         s_axis_tuser,  // func
	// stream out
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [dlr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // pixel_x, pixel_y, blend_weight
	output logic [0:0]                         m_axis_tuser,  // visible
	output logic                               m_axis_tlast,
	// configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [dlr_pkg::APB_AW-1:0]         paddr,
	input  logic [dlr_pkg::APB_DW-1:0]         pwdata,
	output logic [dlr_pkg::APB_DW-1:0]         prdata,
	output logic                               pready
);

	dlr_pkg::cfg_t      cfg;
	dlr_pkg::div_req_t  div_req;
	dlr_pkg::div_rsp_t  div_rsp;
	dlr_pkg::result_t   res;
	logic               out_free;

	logic                               m_valid_q;
	logic [dlr_pkg::OUT_DATA_W-1:0]     m_data_q;
	logic                               m_vis_q;
	logic                               m_last_q;

	dlr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dlr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	dlr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.s_tdata  (s_axis_tdata),
		.s_tfunc  (s_axis_tuser[0]),
		.out_free (out_free),
		.res      (res),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

	assign out_free = !m_valid_q || m_axis_tready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_data_q <= {res.blend_weight, res.pixel_y, res.pixel_x};
			m_vis_q  <= res.visible;
			m_last_q <= res.last;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_vis_q;
	assign m_axis_tlast    = m_last_q;

endmodule

FILE: rtl/dlr_regs.sv
// ---------------------------------------------------------------------------
// dlr_regs
// APB configuration registers: screen width, screen height, step limit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dlr_pkg::APB_AW-1:0]    paddr,
	input  logic [dlr_pkg::APB_DW-1:0]    pwdata,
	output logic [dlr_pkg::APB_DW-1:0]    prdata,
	output logic                          pready,
	output dlr_pkg::cfg_t                 cfg
);

	dlr_pkg::cfg_t      cfg_q;
	dlr_pkg::reg_idx_t  idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = dlr_pkg::reg_idx_t'(paddr[dlr_pkg::APB_AW-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes; unmapped word address is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= dlr_pkg::WIDTH_RST;
			cfg_q.screen_height <= dlr_pkg::HEIGHT_RST;
			cfg_q.step_limit    <= dlr_pkg::LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				dlr_pkg::REG_SCREEN_WIDTH: begin
					cfg_q.screen_width <= pwdata[dlr_pkg::DIM_W-1:0];
				end
				dlr_pkg::REG_SCREEN_HEIGHT: begin
					cfg_q.screen_height <= pwdata[dlr_pkg::DIM_W-1:0];
				end
				dlr_pkg::REG_STEP_LIMIT: begin
					cfg_q.step_limit <= pwdata[dlr_pkg::LIMIT_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (idx)
			dlr_pkg::REG_SCREEN_WIDTH:  prdata = dlr_pkg::APB_DW'(cfg_q.screen_width);
			dlr_pkg::REG_SCREEN_HEIGHT: prdata = dlr_pkg::APB_DW'(cfg_q.screen_height);
			dlr_pkg::REG_STEP_LIMIT:    prdata = dlr_pkg::APB_DW'(cfg_q.step_limit);
			default:                    prdata = '0;
		endcase
	end

endmodule

FILE: rtl/dlr_divider.sv
// ---------------------------------------------------------------------------
// dlr_divider
// Shared restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// The caller guarantees numer >> QUO_W < denom, so the quotient fits in
// QUO_W bits and the partial remainder always stays below the divisor.
module dlr_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  dlr_pkg::div_req_t  req,
	output dlr_pkg::div_rsp_t  rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [dlr_pkg::CNT_W-1:0]   cnt_q;
	logic [dlr_pkg::DIFF_W-1:0]  rem_q;
	logic [dlr_pkg::DIFF_W-1:0]  den_q;
	logic [dlr_pkg::QUO_W-1:0]   numer_q;
	logic [dlr_pkg::QUO_W-1:0]   quo_q;
	logic [dlr_pkg::DIFF_W:0]    trial;
	logic [dlr_pkg::DIFF_W:0]    diff;
	logic                        ge;
	logic [dlr_pkg::DIFF_W-1:0]  rem_next;

	// one trial subtract per cycle
	always_comb begin
		trial    = {rem_q, numer_q[dlr_pkg::QUO_W-1]};
		diff     = trial - {1'b0, den_q};
		ge       = (trial >= {1'b0, den_q});
		rem_next = ge ? diff[dlr_pkg::DIFF_W-1:0] : trial[dlr_pkg::DIFF_W-1:0];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= dlr_pkg::CNT_W'(dlr_pkg::QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == dlr_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q   <= dlr_pkg::DIFF_W'(req.numer[dlr_pkg::NUM_W-1:dlr_pkg::QUO_W]);
			numer_q <= req.numer[dlr_pkg::QUO_W-1:0];
			den_q   <= req.denom;
		end else if (busy_q) begin
			rem_q   <= rem_next;
			numer_q <= numer_q << 1;
			quo_q   <= {quo_q[dlr_pkg::QUO_W-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

FILE: rtl/dlr_core.sv
// ---------------------------------------------------------------------------
// dlr_core
// Sequencer and line state: load setup through the divider, step walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlr_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dlr_pkg::cfg_t                    cfg,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dlr_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                             s_tfunc,
	input  logic                             out_free,
	output dlr_pkg::result_t                 res,
	output dlr_pkg::div_req_t                div_req,
	input  dlr_pkg::div_rsp_t                div_rsp
);

	localparam int PW = dlr_pkg::POS_W;
	localparam int DW = dlr_pkg::DIFF_W;
	localparam int FB = dlr_pkg::FRAC_BITS;
	localparam int TW = dlr_pkg::TRUNC_W;

	dlr_pkg::state_t state_q, state_d;

	// architectural line state
	logic [PW-1:0]                  cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [PW-1:0]                  inc_x_q, inc_y_q;
	logic [dlr_pkg::WGT_W-1:0]      wacc_q, winc_q;
	logic [dlr_pkg::LIMIT_BITS-1:0] steps_q;
	logic                           walking_q;

	// load setup temporaries
	logic signed [DW-1:0]           dx_q, dy_q;
	logic [DW-1:0]                  adx_q, ady_q, m_q;
	logic                           neg_x_q, neg_y_q;

	logic signed [PW-1:0]           start_x, start_y, end_x, end_y;
	logic                           accept;
	logic                           m_small;
	logic [PW-1:0]                  quot_pos;

	// step evaluation
	logic signed [DW-1:0]           dsx, dsy;
	logic                           near_x, near_y, ended;
	logic [TW-1:0]                  tx, ty;
	logic                           vis_x, vis_y, vis;
	logic [dlr_pkg::WGT_W:0]        wsum;
	logic [dlr_pkg::WGT_W-1:0]      wacc_next;
	logic                           step_go;

	// truncated difference is zero when -1.0 < d < 1.0
	function automatic logic near_zero(input logic [DW-1:0] d);
		logic [DW-FB-1:0] hi;
		logic [FB-1:0]    lo;
		hi = d[DW-1:FB];
		lo = d[FB-1:0];
		return (hi == '0) || ((&hi) && (lo != '0));
	endfunction

	assign start_x = s_tdata[PW-1:0];
	assign start_y = s_tdata[2*PW-1:PW];
	assign end_x   = s_tdata[3*PW-1:2*PW];
	assign end_y   = s_tdata[4*PW-1:3*PW];

	assign s_tready = (state_q == dlr_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_small  = (m_q[DW-1:FB] == '0);
	assign quot_pos = PW'(div_rsp.quot);

	// divider request
	always_comb begin
		div_req.start = (state_q inside {dlr_pkg::ST_DIV_X, dlr_pkg::ST_DIV_Y,
			dlr_pkg::ST_DIV_W}) && !div_rsp.busy && !div_rsp.done;
		div_req.denom = m_q;
		case (state_q)
			dlr_pkg::ST_DIV_X: div_req.numer = {adx_q, FB'(0)};
			dlr_pkg::ST_DIV_Y: div_req.numer = {ady_q, FB'(0)};
			default:           div_req.numer = dlr_pkg::WEIGHT_NUM;
		endcase
	end

	// step evaluation against current state
	always_comb begin
		dsx    = DW'($signed(cur_x_q)) - DW'($signed(tgt_x_q));
		dsy    = DW'($signed(cur_y_q)) - DW'($signed(tgt_y_q));
		near_x = near_zero(dsx);
		near_y = near_zero(dsy);
		ended  = !walking_q || (steps_q == '0) || (near_x && near_y);

		tx    = cur_x_q[PW-2:FB];
		ty    = cur_y_q[PW-2:FB];
		vis_x = !cur_x_q[PW-1] && (tx < dlr_pkg::PIX_LIMIT) &&
			(tx < TW'(cfg.screen_width));
		vis_y = !cur_y_q[PW-1] && (ty < dlr_pkg::PIX_LIMIT) &&
			(ty < TW'(cfg.screen_height));
		vis   = vis_x && vis_y && !ended;

		wsum      = {1'b0, wacc_q} + {1'b0, winc_q};
		wacc_next = (wsum > {1'b0, dlr_pkg::WEIGHT_ONE}) ? dlr_pkg::WEIGHT_ONE :
			wsum[dlr_pkg::WGT_W-1:0];

		step_go = (state_q == dlr_pkg::ST_STEP) && out_free;

		res.valid        = step_go;
		res.pixel_x      = vis ? tx[dlr_pkg::PIX_W-1:0] : '0;
		res.pixel_y      = vis ? ty[dlr_pkg::PIX_W-1:0] : '0;
		res.blend_weight = wacc_q[dlr_pkg::WGT_W-1] ? '1 :
			wacc_q[dlr_pkg::OUT_WGT_W-1:0];
		res.visible      = vis;
		res.last         = ended;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dlr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (s_tfunc == dlr_pkg::FUNC_STEP) ? dlr_pkg::ST_STEP :
						dlr_pkg::ST_ABS;
				end
			end
			dlr_pkg::ST_ABS:  state_d = dlr_pkg::ST_MAX;
			dlr_pkg::ST_MAX:  state_d = dlr_pkg::ST_PLAN;
			dlr_pkg::ST_PLAN: begin
				state_d = (m_q == '0) ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIV_X;
			end
			dlr_pkg::ST_DIV_X: begin
				if (div_rsp.done) state_d = dlr_pkg::ST_DIV_Y;
			end
			dlr_pkg::ST_DIV_Y: begin
				if (div_rsp.done) begin
					state_d = m_small ? dlr_pkg::ST_IDLE : dlr_pkg::ST_DIV_W;
				end
			end
			dlr_pkg::ST_DIV_W: begin
				if (div_rsp.done) state_d = dlr_pkg::ST_IDLE;
			end
			dlr_pkg::ST_STEP: begin
				if (out_free) state_d = dlr_pkg::ST_IDLE;
			end
			default: state_d = dlr_pkg::ST_IDLE;
		endcase
	end

	// line state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			inc_x_q   <= '0;
			inc_y_q   <= '0;
			wacc_q    <= '0;
			winc_q    <= '0;
			steps_q   <= '0;
			walking_q <= 1'b0;
		end else begin
			// new line replaces any walk in progress
			if (accept && (s_tfunc == dlr_pkg::FUNC_LOAD)) begin
				cur_x_q   <= start_x;
				cur_y_q   <= start_y;
				tgt_x_q   <= end_x;
				tgt_y_q   <= end_y;
				wacc_q    <= '0;
				steps_q   <= cfg.step_limit;
				walking_q <= 1'b1;
			end
			// zero-length line
			if ((state_q == dlr_pkg::ST_PLAN) && (m_q == '0)) begin
				inc_x_q <= '0;
				inc_y_q <= '0;
				winc_q  <= dlr_pkg::WEIGHT_ONE;
			end
			if ((state_q == dlr_pkg::ST_DIV_X) && div_rsp.done) begin
				inc_x_q <= neg_x_q ? (PW'(0) - quot_pos) : quot_pos;
			end
			if ((state_q == dlr_pkg::ST_DIV_Y) && div_rsp.done) begin
				inc_y_q <= neg_y_q ? (PW'(0) - quot_pos) : quot_pos;
				// count below 2^FRAC: 1/count exceeds 1.0, saturate
				if (m_small) winc_q <= dlr_pkg::WEIGHT_ONE;
			end
			if ((state_q == dlr_pkg::ST_DIV_W) && div_rsp.done) begin
				winc_q <= dlr_pkg::WGT_W'(div_rsp.quot);
			end
			// walk one step
			if (step_go) begin
				if (ended) begin
					walking_q <= 1'b0;
				end else begin
					steps_q <= steps_q - 1'b1;
					cur_x_q <= cur_x_q - inc_x_q;
					cur_y_q <= cur_y_q - inc_y_q;
					wacc_q  <= wacc_next;
				end
			end
		end
	end

	// load setup: difference, magnitude, larger axis
	always_ff @(posedge clk) begin
		case (state_q)
			dlr_pkg::ST_IDLE: begin
				dx_q <= DW'(start_x) - DW'(end_x);
				dy_q <= DW'(start_y) - DW'(end_y);
			end
			dlr_pkg::ST_ABS: begin
				neg_x_q <= dx_q[DW-1];
				neg_y_q <= dy_q[DW-1];
				adx_q   <= dx_q[DW-1] ? (DW'(0) - dx_q) : dx_q;
				ady_q   <= dy_q[DW-1] ? (DW'(0) - dy_q) : dy_q;
			end
			dlr_pkg::ST_MAX: begin
				m_q <= (adx_q > ady_q) ? adx_q : ady_q;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/dlr_checker.sv
// ---------------------------------------------------------------------------
// dlr_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module dlr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [dlr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [0:0]                     m_axis_tuser,
	input logic                           m_axis_tlast
);

	logic out_vis;
	logic out_hidden;
	logic out_wait;
	logic in_take;

	// handshake and flag terms seen on the ports
	assign out_vis    = m_axis_tvalid && m_axis_tuser[0];
	assign out_hidden = m_axis_tvalid && !m_axis_tuser[0];
	assign out_wait   = m_axis_tvalid && !m_axis_tready;
	assign in_take    = s_axis_tvalid && s_axis_tready;

	// a plotted pixel never closes the line
	`ASSERT_IMPLIES(a_vis_not_last, clk, arst_n, out_vis, !m_axis_tlast)

	// hidden or ending words carry pixel zero
	`ASSERT_IMPLIES(a_hidden_zero, clk, arst_n, out_hidden, m_axis_tdata[23:0] == 24'd0)

	// the block is busy, not ready, in the cycle after it accepts a word
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_take, !s_axis_tready)

	// stalled output word holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (.*);
